// ===== sv/rdc_pkg.sv =====
// Package for the region dominant color block: payload structs, register
// indexes, widths and the command/status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package rdc_pkg;

  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned DEF_NUM_COLORS        = 256;
  localparam int unsigned DEF_MAX_REGION_PIXELS = 4096;

  // Largest value of the count field.
  localparam int unsigned COUNT_FIELD_MAX = 8191;

  // Black is always excluded when exclusion is on.
  localparam logic [COLOR_W-1:0] COLOR_BLACK = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 2'd1;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] dominant_color;
    logic [COUNT_W-1:0] dominant_count;
    logic               region_empty;
  } out_t;

  typedef struct packed {
    logic pix_load;    // a pixel transfer happens this cycle
    logic clear_wr;    // write zero at the sweep counter (post-reset clear)
    logic scan_issue;  // read the histogram at the sweep counter
    logic best_clr;    // start a new maximum search
    logic out_load;    // move the search result into the output register
  } cmd_t;

  typedef struct packed {
    logic cnt_end;     // sweep counter sits on the last bin
    logic out_free;    // output register can take a new result this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== sv/region_dominant_color_top.sv =====
// Top level of the region dominant color block: joins controller and datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_datapath (and rdc_ram through it).
//
//   Channel  Handshake              Payload                  Meaning
//   in       in_valid / in_ready    in_data   (rdc_pkg::in_t)   one pixel of a region
//   out      out_valid / out_ready  out_data  (rdc_pkg::out_t)  dominant color result
//   cfg      cfg_we                 cfg_index, cfg_data         register write
//
// Pixels are taken at one per cycle; each transfer is a read-modify-write of one
// histogram bin in the RAM, with a bypass for back-to-back hits on one bin. After the
// pixel marked last, input is held off while the controller steps through its write-back,
// the scan over every bin (which also zeroes each bin), the last read and the load of the
// output register, which is delayed only while the previous result still waits. After
// reset a clearing pass over every bin runs first; configuration writes go anytime.
`default_nettype none

module region_dominant_color_top #(
  parameter int unsigned NUM_COLORS        = rdc_pkg::DEF_NUM_COLORS,
  parameter int unsigned MAX_REGION_PIXELS = rdc_pkg::DEF_MAX_REGION_PIXELS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rdc_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rdc_pkg::out_t                       out_data
);

  // Commands flow from the controller; the datapath reports counter and output state.
  rdc_pkg::cmd_t    cmd;
  rdc_pkg::status_t status;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_pixel),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rdc_datapath #(
    .NUM_COLORS        (NUM_COLORS),
    .MAX_REGION_PIXELS (MAX_REGION_PIXELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/rdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rdc_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rdc_datapath.sv =====
// Datapath of the region dominant color block: configuration registers,
// histogram RAM with read-modify-write and bypass, maximum search, output register.
// Depends on rdc_pkg and rdc_ram.
`default_nettype none

module rdc_datapath #(
  parameter int unsigned NUM_COLORS        = rdc_pkg::DEF_NUM_COLORS,
  parameter int unsigned MAX_REGION_PIXELS = rdc_pkg::DEF_MAX_REGION_PIXELS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire rdc_pkg::in_t                    in_data,
  input  wire rdc_pkg::cmd_t                   cmd,
  output rdc_pkg::status_t                     status,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rdc_pkg::out_t                        out_data
);

  localparam int unsigned ADDR_W  = $clog2(NUM_COLORS);
  localparam int unsigned SAT_INT = (MAX_REGION_PIXELS < rdc_pkg::COUNT_FIELD_MAX) ?
                                    MAX_REGION_PIXELS : rdc_pkg::COUNT_FIELD_MAX;
  localparam logic [rdc_pkg::COUNT_W-1:0] SAT_LIMIT = rdc_pkg::COUNT_W'(SAT_INT);
  localparam logic [ADDR_W-1:0]           LAST_BIN  = ADDR_W'(NUM_COLORS - 1);

  // Configuration.
  logic                         exclude_enable;
  logic [rdc_pkg::COLOR_W-1:0]  background_color;

  // Pixel pipeline stage: the RAM read of this pixel is in flight.
  logic                         s1_valid;
  logic                         s1_counted;
  logic [ADDR_W-1:0]            s1_addr;
  logic                         fwd_hit;
  logic [rdc_pkg::COUNT_W-1:0]  fwd_val;

  // Sweep counter and scan stage.
  logic [ADDR_W-1:0]            cnt;
  logic                         scan_d;
  logic [ADDR_W-1:0]            scan_addr_d;

  // Running maximum.
  logic [rdc_pkg::COUNT_W-1:0]  best_count;
  logic [ADDR_W-1:0]            best_idx;

  // RAM ports.
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [rdc_pkg::COUNT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [rdc_pkg::COUNT_W-1:0]  ram_rdata;

  logic [ADDR_W-1:0]            pix_addr;
  logic                         pix_counted;
  logic [rdc_pkg::COUNT_W-1:0]  cur_count;
  logic                         pix_we;
  logic [rdc_pkg::COUNT_W-1:0]  pix_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      exclude_enable   <= 1'b1;
      background_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdc_pkg::CFG_EXCLUDE_ENABLE:   exclude_enable   <= cfg_data[0];
        rdc_pkg::CFG_BACKGROUND_COLOR: background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_addr    = ADDR_W'(in_data.pixel_color);
  assign pix_counted = ({24'd0, in_data.pixel_color} < 32'(NUM_COLORS)) &&
                       !(exclude_enable &&
                         ((in_data.pixel_color == rdc_pkg::COLOR_BLACK) ||
                          (in_data.pixel_color == background_color)));

  // A write of the previous pixel to the same bin is not yet visible in the
  // read data, so it is forwarded.
  assign cur_count = fwd_hit ? fwd_val : ram_rdata;
  assign pix_we    = s1_valid && s1_counted && (cur_count < SAT_LIMIT);
  assign pix_wdata = cur_count + 1'b1;

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = cnt;
    ram_wdata = '0;
    priority if (pix_we) begin
      ram_waddr = s1_addr;
      ram_wdata = pix_wdata;
    end else if (scan_d) begin
      ram_waddr = scan_addr_d;
    end else if (cmd.clear_wr) begin
      ram_waddr = cnt;
    end else begin
      ram_we = 1'b0;
    end
  end

  assign ram_raddr = cmd.scan_issue ? cnt : pix_addr;

  rdc_ram #(
    .WIDTH (rdc_pkg::COUNT_W),
    .DEPTH (NUM_COLORS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      scan_d   <= 1'b0;
      cnt      <= '0;
    end else begin
      s1_valid <= cmd.pix_load;
      scan_d   <= cmd.scan_issue;
      if (cmd.scan_issue || cmd.clear_wr) begin
        cnt <= (cnt == LAST_BIN) ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      s1_addr    <= pix_addr;
      s1_counted <= pix_counted;
      fwd_hit    <= pix_we && (s1_addr == pix_addr);
      fwd_val    <= pix_wdata;
    end
    scan_addr_d <= cnt;
  end

  // Strictly greater keeps the lowest bin on ties, since the scan ascends.
  always_ff @(posedge clk) begin
    if (cmd.best_clr) begin
      best_count <= '0;
      best_idx   <= '0;
    end else if (scan_d && (ram_rdata > best_count)) begin
      best_count <= ram_rdata;
      best_idx   <= scan_addr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.dominant_color <= rdc_pkg::COLOR_W'(best_idx);
      out_data.dominant_count <= best_count;
      out_data.region_empty   <= (best_count == '0);
    end
  end

  assign status.cnt_end  = (cnt == LAST_BIN);
  assign status.out_free = !out_valid || out_ready;

  // The pixel write and the scan's clearing write never compete for the port.
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(pix_we && scan_d))
    else $error("pixel update collides with scan clear");

  // Scan reads never overlap a pixel still being accumulated.
  a_scan_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> !s1_valid && !cmd.pix_load)
    else $error("histogram scan started with a pixel in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.region_empty == (out_data.dominant_count == '0)))
    else $error("empty flag disagrees with dominant count");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.dominant_count <= SAT_LIMIT))
    else $error("dominant count above saturation limit");

endmodule

`default_nettype wire

// ===== sv/rdc_ctrl.sv =====
// Controller of the region dominant color block: sequences the post-reset clear,
// pixel accumulation, histogram scan and result hand-off. Depends on rdc_pkg.
`default_nettype none

module rdc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  output logic                  in_ready,
  input  wire rdc_pkg::status_t status,
  output rdc_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.cnt_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.pix_load = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last pixel's count is written back in this cycle.
        cmd.best_clr = 1'b1;
        state_next   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.cnt_end) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // A pixel transfer can only happen in ST_IDLE, so ready is the decoded next state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== test/region_dominant_color_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for region_dominant_color_top: pixel regions go in, and
// each dominant color result is checked against a histogram predictor kept here.
// Depends on rdc_pkg and region_dominant_color_top.
module region_dominant_color_top_test;

  // A bin stops counting at the smaller of the region size limit and the field maximum.
  localparam int unsigned TALLY_CAP =
      (rdc_pkg::DEF_MAX_REGION_PIXELS < rdc_pkg::COUNT_FIELD_MAX) ?
      rdc_pkg::DEF_MAX_REGION_PIXELS : rdc_pkg::COUNT_FIELD_MAX;
  // Register indexes with no register behind them; writes there must change nothing.
  localparam logic [rdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [rdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = rdc_pkg::DEF_NUM_COLORS + 8;
  localparam int unsigned LONG_RUN     = 40;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  rdc_pkg::in_t                   in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rdc_pkg::out_t                  out_data;

  region_dominant_color_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Predictor state: per-color counts and a copy of both registers.
  logic [rdc_pkg::COUNT_W-1:0] color_tally [rdc_pkg::DEF_NUM_COLORS];
  logic                        excl_on;
  logic [rdc_pkg::COLOR_W-1:0] bg_color;
  rdc_pkg::out_t               expected_results [$];

  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Counts one accepted pixel; the last pixel of a region also yields the
  // expected result (highest count, lowest color on ties) and clears the counts.
  function automatic void tally_pixel(input rdc_pkg::in_t px);
    int unsigned                 peak;
    logic [rdc_pkg::COLOR_W-1:0] peak_color;
    rdc_pkg::out_t               res;
    peak       = 0;
    peak_color = '0;
    if (!(excl_on && (px.pixel_color == rdc_pkg::COLOR_BLACK ||
                      px.pixel_color == bg_color)) &&
        color_tally[px.pixel_color] < TALLY_CAP)
      color_tally[px.pixel_color]++;
    if (px.last_pixel) begin
      for (int c = 0; c < rdc_pkg::DEF_NUM_COLORS; c++) begin
        if (color_tally[c] > peak) begin
          peak       = color_tally[c];
          peak_color = rdc_pkg::COLOR_W'(c);
        end
        color_tally[c] = '0;
      end
      res.dominant_color = peak_color;
      res.dominant_count = rdc_pkg::COUNT_W'(peak);
      res.region_empty   = (peak == 0);
      expected_results   = {expected_results, res};
    end
  endfunction

  // The receiver stalls at random; recv_stall_pct of zero keeps it always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    rdc_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no result expected: color %0d count %0d empty %0b",
               out_data.dominant_color, out_data.dominant_count, out_data.region_empty);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.dominant_color !== want.dominant_color) begin
          $error("dominant_color: expected %0d, got %0d",
                 want.dominant_color, out_data.dominant_color);
          error_count++;
        end
        if (out_data.dominant_count !== want.dominant_count) begin
          $error("dominant_count: expected %0d, got %0d",
                 want.dominant_count, out_data.dominant_count);
          error_count++;
        end
        if (out_data.region_empty !== want.region_empty) begin
          $error("region_empty: expected %0b, got %0b",
                 want.region_empty, out_data.region_empty);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one pixel, after a random idle gap, and holds it until the transfer.
  // Valid stays high afterwards so back-to-back pixels need no second assignment.
  task automatic send_pixel(input logic [rdc_pkg::COLOR_W-1:0] color, input logic last);
    rdc_pkg::in_t px;
    px.pixel_color = color;
    px.last_pixel  = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    tally_pixel(px);
  endtask

  // Writes one register and mirrors it; out-of-range indexes are ignored and
  // the enable keeps only its low bit.
  task automatic write_reg(input logic [rdc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [rdc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      rdc_pkg::CFG_EXCLUDE_ENABLE: begin
        excl_on = value[0];
      end
      rdc_pkg::CFG_BACKGROUND_COLOR: begin
        bg_color = value;
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // Stops the sender and waits until every expected result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_register_writes();
    // Spare indexes must leave background and exclusion as they are.
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, 8'hFF);
    write_reg(rdc_pkg::CFG_BACKGROUND_COLOR, 8'h2A);
    write_reg(CFG_SPARE_A, 8'h00);
    write_reg(CFG_SPARE_B, 8'h00);
    send_pixel(8'h2A, 1'b0);
    send_pixel(8'h2A, 1'b0);
    send_pixel(8'h05, 1'b1);
    settle();
    // Only bit 0 of the enable counts, so this turns exclusion off.
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, 8'hFE);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h07, 1'b1);
    settle();
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, 8'h01);
  endtask

  task automatic test_empty_region();
    // A lone excluded pixel, then a region of black and background only.
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h2A, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h2A, 1'b1);
    settle();
  endtask

  task automatic test_tie_lowest();
    send_pixel(8'h09, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h09, 1'b0);
    send_pixel(8'h03, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFE, 1'b1);
    settle();
  endtask

  task automatic test_extreme_colors();
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    settle();
    // Background at the top of the palette.
    write_reg(rdc_pkg::CFG_BACKGROUND_COLOR, 8'hFF);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b1);
    settle();
  endtask

  task automatic test_no_exclusion();
    // Black counts and wins a tie against a higher color.
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, 8'h00);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h05, 1'b1);
    send_pixel(8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_long_region();
    // One long single-color region, then a short one to show the bin was cleared.
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, 8'h01);
    write_reg(rdc_pkg::CFG_BACKGROUND_COLOR, 8'h00);
    for (int n = 0; n < LONG_RUN; n++) send_pixel(8'h80, 1'b0);
    send_pixel(8'h80, 1'b1);
    send_pixel(8'h80, 1'b1);
    settle();
  endtask

  // Regions of random length; half of the pixels come from a small per-region palette
  // so that clear winners and ties both occur, the rest are black, background
  // or any color.
  task automatic run_random_phase(input logic excl, input logic [rdc_pkg::COLOR_W-1:0] bg,
                                  input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned pixels);
    int unsigned                 sent;
    int unsigned                 len;
    int unsigned                 pick;
    logic [rdc_pkg::COLOR_W-1:0] palette [4];
    logic [rdc_pkg::COLOR_W-1:0] color;
    sent = 0;
    settle();
    write_reg(rdc_pkg::CFG_EXCLUDE_ENABLE, rdc_pkg::CFG_DATA_W'(excl));
    write_reg(rdc_pkg::CFG_BACKGROUND_COLOR, bg);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < pixels) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      foreach (palette[k]) palette[k] = rdc_pkg::COLOR_W'($urandom);
      for (int n = 0; n < len; n++) begin
        pick = $urandom_range(99);
        if (pick < 50)
          color = palette[$urandom_range(3)];
        else if (pick < 62)
          color = rdc_pkg::COLOR_BLACK;
        else if (pick < 75)
          color = bg;
        else
          color = rdc_pkg::COLOR_W'($urandom);
        send_pixel(color, n == len - 1);
      end
      sent += len;
    end
    settle();
  endtask

  initial begin
    excl_on  = 1'b1;
    bg_color = '0;
    foreach (color_tally[c]) color_tally[c] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_register_writes();
    test_empty_region();
    test_tie_lowest();
    test_extreme_colors();
    test_no_exclusion();
    test_long_region();

    run_random_phase(1'b1, rdc_pkg::COLOR_W'($urandom), 0, 0, 245);
    run_random_phase(1'b0, 8'hFF, 59, 0, 245);
    run_random_phase(1'b1, 8'hFF, 0, 59, 245);
    run_random_phase(1'b1, 8'h00, 20, 20, 245);

    // Give a stray result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
